// ===== design/pke_pkg.sv =====
// ----------------------------------------------------------------------------
// pke_pkg
// Widths, types and constants shared by the kernel evaluator and its divider.
// ----------------------------------------------------------------------------
package pke_pkg;

  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 24;
  localparam int OUT_BITS   = 36;

  // square or cross product of two components
  localparam int SQ_W   = 2 * COORD_BITS;
  // norms and |q.p|, unsigned
  localparam int NORM_W = 2 * COORD_BITS;
  // signed working width for the sums of three products
  localparam int EXT_W  = 2 * COORD_BITS + 3;
  // |q + p|^2, unsigned
  localparam int SUM_W  = 2 * COORD_BITS + 2;
  localparam int PROD_W = 4 * COORD_BITS + 2;
  localparam int MAG_W  = 4 * COORD_BITS + 5;
  localparam int DEN_W  = 4 * COORD_BITS + 4;
  localparam int D2_W   = DEN_W + 1;
  localparam int REM_W  = D2_W + 1;
  localparam int NUM_RAW_W = MAG_W + FRAC_BITS + 2;
  localparam int NUM_W  = (NUM_RAW_W > OUT_BITS + D2_W) ? NUM_RAW_W : OUT_BITS + D2_W;

  localparam logic [1:0] MODE_ALPHA = 2'd0;
  localparam logic [1:0] MODE_BETA  = 2'd1;
  localparam logic [1:0] MODE_F2    = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SQ_W-1:0]       sq_t;
  typedef logic signed [EXT_W-1:0]      ext_t;
  typedef logic [NORM_W-1:0]            norm_t;
  typedef logic [SUM_W-1:0]             sum_t;
  typedef logic [PROD_W-1:0]            prod_t;
  typedef logic [MAG_W-1:0]             mag_t;
  typedef logic [DEN_W-1:0]             den_t;
  typedef logic [D2_W-1:0]              d2_t;
  typedef logic [REM_W-1:0]             rem_t;
  typedef logic [NUM_W-1:0]             num_t;
  typedef logic [OUT_BITS-1:0]          kv_t;

  // 5/7 in output format, the F2 kernel value whenever a norm is zero
  localparam kv_t KV_F2_ZERO = kv_t'(((64'd5 << (FRAC_BITS + 1)) + 64'd7) / 14);

  typedef struct packed {
    logic neg;
    logic zero;
    mag_t mag;
    den_t den;
  } div_req_t;

endpackage

// ===== design/pke_div.sv =====
// ----------------------------------------------------------------------------
// pke_div
// Pipelined restoring divider: round(mag / den) in output fixed point, one
// quotient bit per stage, then saturate and apply the sign.
// ----------------------------------------------------------------------------
module pke_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              req_valid,
  input  pke_pkg::div_req_t req,
  output logic              out_valid,
  output pke_pkg::kv_t      kernel_value,
  output logic              zero_norm
);

  localparam int OB = pke_pkg::OUT_BITS;

  logic              vld  [OB+1];
  logic              neg  [OB+1];
  logic              zro  [OB+1];
  logic              ovf  [OB+1];
  pke_pkg::rem_t     rem  [OB+1];
  pke_pkg::d2_t      d2   [OB+1];
  pke_pkg::kv_t      low  [OB+1];
  pke_pkg::kv_t      quo  [OB+1];

  pke_pkg::num_t num;
  pke_pkg::num_t num_hi;
  pke_pkg::d2_t  d2_in;

  // numerator gets half the divisor added so the quotient rounds to nearest
  always_comb begin
    d2_in  = {req.den, 1'b0};
    num    = (pke_pkg::num_t'(req.mag) << (pke_pkg::FRAC_BITS + 1))
             + pke_pkg::num_t'(req.den);
    num_hi = num >> OB;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (advance) begin
      vld[0] <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      neg[0] <= req.neg;
      zro[0] <= req.zero;
      ovf[0] <= num_hi >= pke_pkg::num_t'(d2_in);
      rem[0] <= pke_pkg::rem_t'(num_hi);
      d2[0]  <= d2_in;
      low[0] <= pke_pkg::kv_t'(num);
      quo[0] <= '0;
    end
  end

  for (genvar j = 1; j <= OB; j++) begin : g_stage
    pke_pkg::rem_t trial;
    logic          take;

    always_comb begin
      trial = {rem[j-1][pke_pkg::REM_W-2:0], low[j-1][OB-1]};
      take  = trial >= pke_pkg::rem_t'(d2[j-1]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (advance) begin
        vld[j] <= vld[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        neg[j] <= neg[j-1];
        zro[j] <= zro[j-1];
        ovf[j] <= ovf[j-1];
        d2[j]  <= d2[j-1];
        low[j] <= low[j-1] << 1;
        quo[j] <= {quo[j-1][OB-2:0], take};
        rem[j] <= take ? trial - pke_pkg::rem_t'(d2[j-1]) : trial;
      end
    end
  end

  pke_pkg::kv_t lim;
  pke_pkg::kv_t mag_sat;

  always_comb begin
    lim     = neg[OB] ? (pke_pkg::kv_t'(1) << (OB - 1))
                      : (pke_pkg::kv_t'(1) << (OB - 1)) - pke_pkg::kv_t'(1);
    mag_sat = (ovf[OB] || quo[OB] > lim) ? lim : quo[OB];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= vld[OB];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kernel_value <= neg[OB] ? -mag_sat : mag_sat;
      zero_norm    <= zro[OB];
    end
  end

endmodule

// ===== design/perturbation_kernel_evaluator.sv =====
// ----------------------------------------------------------------------------
// perturbation_kernel_evaluator
// Alpha, beta and second-order F2 kernels of two integer wavevectors.
// ----------------------------------------------------------------------------
// One transaction per cycle enters and leaves unless the pipeline is held: five
// stages form norms, dot product and the kernel's rational numerator and
// denominator, then a divider resolves one quotient bit per stage across the
// 36 output bits before the rounded, saturated Q11.24 value is registered.
// The whole pipeline holds while a result waits with out_stall high.
module perturbation_kernel_evaluator (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           mode,
  input  pke_pkg::coord_t      q_x,
  input  pke_pkg::coord_t      q_y,
  input  pke_pkg::coord_t      q_z,
  input  pke_pkg::coord_t      p_x,
  input  pke_pkg::coord_t      p_y,
  input  pke_pkg::coord_t      p_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [pke_pkg::OUT_BITS-1:0] kernel_value,
  output logic                 zero_norm
);

  logic advance;
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // stage 1: input capture
  logic            v1;
  logic [1:0]      mode1;
  pke_pkg::coord_t qx1, qy1, qz1, px1, py1, pz1;

  // stage 2: component products
  logic            v2;
  logic [1:0]      mode2;
  pke_pkg::sq_t    qqx, qqy, qqz, ppx, ppy, ppz, qpx, qpy, qpz;

  // stage 3: norms and dot product
  logic            v3;
  logic [1:0]      mode3;
  pke_pkg::norm_t  mq3, mp3, aqp3;
  pke_pkg::sum_t   s3;
  logic            neg3, zero3, mpz3;

  // stage 4: wide products
  logic            v4;
  logic [1:0]      mode4;
  pke_pkg::norm_t  mp4, aqp4;
  pke_pkg::prod_t  mqmp4, aqp24, aqps4, aqpm4;
  logic            neg4, zero4, mpz4;

  // stage 5: divider request
  logic              v5;
  pke_pkg::div_req_t req5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mode1 <= mode;
      qx1 <= q_x;
      qy1 <= q_y;
      qz1 <= q_z;
      px1 <= p_x;
      py1 <= p_y;
      pz1 <= p_z;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mode2 <= mode1;
      qqx <= pke_pkg::sq_t'(qx1) * pke_pkg::sq_t'(qx1);
      qqy <= pke_pkg::sq_t'(qy1) * pke_pkg::sq_t'(qy1);
      qqz <= pke_pkg::sq_t'(qz1) * pke_pkg::sq_t'(qz1);
      ppx <= pke_pkg::sq_t'(px1) * pke_pkg::sq_t'(px1);
      ppy <= pke_pkg::sq_t'(py1) * pke_pkg::sq_t'(py1);
      ppz <= pke_pkg::sq_t'(pz1) * pke_pkg::sq_t'(pz1);
      qpx <= pke_pkg::sq_t'(qx1) * pke_pkg::sq_t'(px1);
      qpy <= pke_pkg::sq_t'(qy1) * pke_pkg::sq_t'(py1);
      qpz <= pke_pkg::sq_t'(qz1) * pke_pkg::sq_t'(pz1);
    end
  end

  pke_pkg::ext_t mq_e, mp_e, qp_e, s_e;
  pke_pkg::norm_t mq_c, mp_c;

  always_comb begin
    mq_e = pke_pkg::ext_t'(qqx) + pke_pkg::ext_t'(qqy) + pke_pkg::ext_t'(qqz);
    mp_e = pke_pkg::ext_t'(ppx) + pke_pkg::ext_t'(ppy) + pke_pkg::ext_t'(ppz);
    qp_e = pke_pkg::ext_t'(qpx) + pke_pkg::ext_t'(qpy) + pke_pkg::ext_t'(qpz);
    // |q + p|^2, never negative
    s_e  = mq_e + mp_e + (qp_e <<< 1);
    mq_c = pke_pkg::norm_t'(mq_e);
    mp_c = pke_pkg::norm_t'(mp_e);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mode3 <= mode2;
      mq3   <= mq_c;
      mp3   <= mp_c;
      s3    <= pke_pkg::sum_t'(s_e);
      aqp3  <= pke_pkg::norm_t'((qp_e < 0) ? -qp_e : qp_e);
      neg3  <= qp_e < 0;
      zero3 <= (mq_c == '0) || (mp_c == '0);
      mpz3  <= mp_c == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mode4 <= mode3;
      mp4   <= mp3;
      aqp4  <= aqp3;
      neg4  <= neg3;
      zero4 <= zero3;
      mpz4  <= mpz3;
      mqmp4 <= pke_pkg::prod_t'(mq3) * pke_pkg::prod_t'(mp3);
      aqp24 <= pke_pkg::prod_t'(aqp3) * pke_pkg::prod_t'(aqp3);
      aqps4 <= pke_pkg::prod_t'(aqp3) * pke_pkg::prod_t'(s3);
      aqpm4 <= pke_pkg::prod_t'(aqp3) * (pke_pkg::prod_t'(mq3) + pke_pkg::prod_t'(mp3));
    end
  end

  pke_pkg::mag_t     mm, pos, tt;
  pke_pkg::div_req_t req_c;

  always_comb begin
    mm  = pke_pkg::mag_t'(mqmp4);
    pos = (mm << 3) + (mm << 1) + (pke_pkg::mag_t'(aqp24) << 2);
    tt  = (pke_pkg::mag_t'(aqpm4) << 3) - pke_pkg::mag_t'(aqpm4);
    req_c.zero = zero4;
    req_c.neg  = 1'b0;
    req_c.mag  = '0;
    req_c.den  = pke_pkg::den_t'(1);
    unique case (mode4)
      pke_pkg::MODE_ALPHA: begin
        if (!mpz4) begin
          req_c.neg = neg4;
          req_c.mag = pke_pkg::mag_t'(aqp4);
          req_c.den = pke_pkg::den_t'(mp4);
        end
      end
      pke_pkg::MODE_BETA: begin
        if (!zero4) begin
          req_c.neg = neg4;
          req_c.mag = pke_pkg::mag_t'(aqps4);
          req_c.den = pke_pkg::den_t'(mm << 1);
        end
      end
      pke_pkg::MODE_F2: begin
        if (zero4) begin
          req_c.mag = pke_pkg::mag_t'(5);
          req_c.den = pke_pkg::den_t'(7);
        end else begin
          req_c.den = pke_pkg::den_t'((mm << 4) - (mm << 1));
          if (!neg4) begin
            req_c.mag = pos + tt;
          end else if (pos >= tt) begin
            req_c.mag = pos - tt;
          end else begin
            req_c.neg = 1'b1;
            req_c.mag = tt - pos;
          end
        end
      end
      default: begin
        req_c.mag = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      req5 <= req_c;
    end
  end

  pke_pkg::kv_t kv_raw;

  pke_div u_div (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .req_valid    (v5),
    .req          (req5),
    .out_valid    (out_valid),
    .kernel_value (kv_raw),
    .zero_norm    (zero_norm)
  );

  assign kernel_value = kv_raw;

`ifndef SYNTHESIS
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    v5 |-> req5.den != '0)
    else $error("divider request with zero denominator");

  a_zero_norm_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_norm |->
      kv_raw == '0 || kv_raw == pke_pkg::KV_F2_ZERO)
    else $error("zero-norm transaction with unexpected kernel value");
`endif

endmodule
